### design/bucketed_varlen_encoder_macros.svh
// Assertion macros for the bucketed variable-length encoder checker.
// Used by bve_checker.sv only; no other dependencies.
`ifndef BUCKETED_VARLEN_ENCODER_MACROS_SVH
`define BUCKETED_VARLEN_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BVE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bve assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BVE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bve assertion failed");

`endif

### design/bve_pkg.sv
// Shared types and constants of the bucketed variable-length encoder.
// No dependencies; every other design file but the macro header takes names from here.
package bve_pkg;

    // default parameter values
    localparam int DATA_WIDTH_DEF   = 64;
    localparam int OFFSET_WIDTH_DEF = 32;

    // fixed field widths
    localparam int VALUE_W   = 64;
    localparam int CODE_W    = 64;
    localparam int LEN_W     = 7;
    localparam int POS_W     = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // longest codeword the output can carry
    localparam int CODE_MAX = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODING      = 2'd0,
        CFG_VALUE_WIDTH = 2'd1,
        CFG_SIGNED      = 2'd2,
        CFG_START       = 2'd3
    } t_cfg_idx;

    // element slice width codes
    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W32 = 2'd2,
        W64 = 2'd3
    } t_width;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_STEP,
        S_FIN,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic set_raw;
        logic set_fail;
        logic step;
        logic latch_hit;
        logic finish;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic raw;
        logic too_big;
        logic hit;
        logic out_free;
    } t_dp_sts;

endpackage

### design/bve_in_if.sv
// Input channel of the encoder: valid/ready handshake plus one element.
// Depends on bve_pkg for field widths.
interface bve_in_if;
    logic                        valid;
    logic                        ready;
    logic [bve_pkg::VALUE_W-1:0] value;
    logic                        last_in_vector;

    modport source (output valid, output value, output last_in_vector, input ready);
    modport sink   (input valid, input value, input last_in_vector, output ready);
endinterface

### design/bve_out_if.sv
// Output channel of the encoder: valid/ready handshake plus one codeword.
// Depends on bve_pkg for field widths.
interface bve_out_if;
    logic                       valid;
    logic                       ready;
    logic [bve_pkg::CODE_W-1:0] codeword;
    logic [bve_pkg::LEN_W-1:0]  code_length;
    logic [bve_pkg::POS_W-1:0]  bit_position;
    logic                       end_of_vector;
    logic                       out_of_range;
    logic                       position_wrapped;

    modport source (output valid, output codeword, output code_length, output bit_position,
                    output end_of_vector, output out_of_range, output position_wrapped,
                    input ready);
    modport sink   (input valid, input codeword, input code_length, input bit_position,
                    input end_of_vector, input out_of_range, input position_wrapped,
                    output ready);
endinterface

### design/bve_ctrl.sv
// Sequencing state machine of the encoder.
// Depends on bve_pkg for the state, command and status types.
module bve_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bve_pkg::t_dp_sts i_sts,
    output bve_pkg::t_dp_cmd o_cmd
);

    bve_pkg::t_state r_state;
    bve_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bve_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bve_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = bve_pkg::S_CHECK;
                end
            end
            bve_pkg::S_CHECK: begin
                if (i_sts.raw || i_sts.too_big) begin
                    n_state = bve_pkg::S_EMIT;
                end else begin
                    n_state = bve_pkg::S_STEP;
                end
            end
            bve_pkg::S_STEP: begin
                if (i_sts.hit) begin
                    n_state = bve_pkg::S_FIN;
                end
            end
            bve_pkg::S_FIN: begin
                n_state = bve_pkg::S_EMIT;
            end
            bve_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = bve_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bve_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bve_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            bve_pkg::S_CHECK: begin
                o_cmd.set_raw  = i_sts.raw;
                o_cmd.set_fail = !i_sts.raw && i_sts.too_big;
            end
            bve_pkg::S_STEP: begin
                o_cmd.latch_hit = i_sts.hit;
                o_cmd.step      = !i_sts.hit;
            end
            bve_pkg::S_FIN: begin
                o_cmd.finish = 1'b1;
            end
            bve_pkg::S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### design/bve_datapath.sv
// Datapath of the encoder: configuration, bucket walk, position and output register.
// Depends on bve_pkg; driven by bve_ctrl through command and status structs.
module bve_datapath #(
    parameter int DATA_WIDTH   = bve_pkg::DATA_WIDTH_DEF,
    parameter int OFFSET_WIDTH = bve_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bve_pkg::t_dp_cmd              i_cmd,
    output bve_pkg::t_dp_sts              o_sts,
    input  logic                          i_cfg_we,
    input  logic [bve_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bve_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [bve_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_last_in_vector,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bve_pkg::CODE_W-1:0]    o_codeword,
    output logic [bve_pkg::LEN_W-1:0]     o_code_length,
    output logic [bve_pkg::POS_W-1:0]     o_bit_position,
    output logic                          o_end_of_vector,
    output logic                          o_out_of_range,
    output logic                          o_position_wrapped
);

    localparam int DW    = DATA_WIDTH;
    localparam int OW    = OFFSET_WIDTH;
    localparam int KW    = $clog2(DATA_WIDTH);
    localparam int TOT_W = $clog2(2 * DATA_WIDTH) + 1;
    localparam int VW    = bve_pkg::VALUE_W;

    // configuration
    logic [DW-1:0]               r_coding;
    bve_pkg::t_width             r_vw;
    logic                        r_signed;
    logic [bve_pkg::POS_W-1:0]   r_start;

    // working registers
    logic [DW-1:0]               r_d;
    logic [DW-1:0]               r_rem;
    logic [KW-1:0]               r_shift;
    logic [KW-1:0]               r_k;
    logic                        r_t;
    logic                        r_last;
    logic [bve_pkg::CODE_W-1:0]  r_code;
    logic [bve_pkg::LEN_W-1:0]   r_len;
    logic                        r_oor;

    // stream state
    logic [OW-1:0]               r_bit_offset;
    logic                        r_at_start;

    // output register
    logic                        r_out_valid;
    logic [bve_pkg::CODE_W-1:0]  r_o_code;
    logic [bve_pkg::LEN_W-1:0]   r_o_len;
    logic [bve_pkg::POS_W-1:0]   r_o_pos;
    logic                        r_o_eov;
    logic                        r_o_oor;
    logic                        r_o_wrap;

    logic [VW-1:0]               slice;
    logic [VW-1:0]               zig;
    logic [DW-1:0]               mapped;
    logic [DW-1:0]               lowbit;
    logic                        is_last;
    logic                        fits;
    logic [KW-1:0]               k;
    logic [TOT_W-1:0]            total;
    logic [DW-1:0]               body;
    logic [bve_pkg::CODE_W-1:0]  fin_code;
    logic                        too_long;
    logic [OW-1:0]               pos;
    logic [OW:0]                 sum;

    // slice, sign-extend and zigzag
    always_comb begin
        unique case (r_vw)
            bve_pkg::W8: begin
                slice = {{(VW-8){r_signed & i_value[7]}}, i_value[7:0]};
            end
            bve_pkg::W16: begin
                slice = {{(VW-16){r_signed & i_value[15]}}, i_value[15:0]};
            end
            bve_pkg::W32: begin
                slice = {{(VW-32){r_signed & i_value[31]}}, i_value[31:0]};
            end
            bve_pkg::W64: begin
                slice = i_value;
            end
            default: begin
                slice = i_value;
            end
        endcase
        if (r_signed) begin
            zig = {slice[VW-2:0], 1'b0} ^ {VW{slice[VW-1]}};
        end else begin
            zig = slice;
        end
        mapped = zig[DW-1:0];
    end

    // one bucket: lowest set bit of what is left of the coding
    always_comb begin
        lowbit  = r_rem & (~r_rem + DW'(1));
        is_last = (lowbit == r_rem);
        fits    = (r_d < lowbit);
        k       = '0;
        for (int i = 0; i < DW; i++) begin
            if (lowbit[i]) begin
                k = k | KW'(i);
            end
        end
    end

    // final code assembly from latched bucket
    always_comb begin
        total    = TOT_W'(r_k) + TOT_W'(r_shift) + TOT_W'(r_t);
        body     = (r_d << r_t) | DW'(r_t);
        fin_code = bve_pkg::CODE_W'(body) << r_shift;
        too_long = (total > TOT_W'(bve_pkg::CODE_MAX));
    end

    // stream position
    always_comb begin
        pos = r_at_start ? OW'(r_start) : r_bit_offset;
        sum = {1'b0, pos} + (OW + 1)'(r_len);
    end

    always_comb begin
        o_sts.raw      = (r_rem == '0);
        o_sts.too_big  = (r_d >= r_rem);
        o_sts.hit      = fits || is_last;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coding     <= '0;
            r_vw         <= bve_pkg::W64;
            r_signed     <= 1'b0;
            r_start      <= '0;
            r_bit_offset <= '0;
            r_at_start   <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (bve_pkg::t_cfg_idx'(i_cfg_index))
                    bve_pkg::CFG_CODING:      r_coding <= i_cfg_data[DW-1:0];
                    bve_pkg::CFG_VALUE_WIDTH: r_vw     <= bve_pkg::t_width'(i_cfg_data[1:0]);
                    bve_pkg::CFG_SIGNED:      r_signed <= i_cfg_data[0];
                    bve_pkg::CFG_START:       r_start  <= i_cfg_data[bve_pkg::POS_W-1:0];
                    default:                  r_signed <= r_signed;
                endcase
            end
            if (i_cmd.emit) begin
                r_bit_offset <= sum[OW-1:0];
                r_at_start   <= r_last;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d     <= mapped;
            r_rem   <= r_coding;
            r_shift <= '0;
            r_last  <= i_last_in_vector;
        end
        if (i_cmd.step) begin
            r_d     <= r_d - lowbit;
            r_rem   <= r_rem ^ lowbit;
            r_shift <= r_shift + KW'(1);
        end
        if (i_cmd.latch_hit) begin
            r_k <= k;
            r_t <= fits && !is_last;
        end
        if (i_cmd.set_raw) begin
            r_code <= bve_pkg::CODE_W'(r_d);
            r_len  <= bve_pkg::LEN_W'(DW);
            r_oor  <= 1'b0;
        end
        if (i_cmd.set_fail || (i_cmd.finish && too_long)) begin
            r_code <= '0;
            r_len  <= '0;
            r_oor  <= 1'b1;
        end else if (i_cmd.finish) begin
            r_code <= fin_code;
            r_len  <= bve_pkg::LEN_W'(total);
            r_oor  <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_o_code <= r_code;
            r_o_len  <= r_len;
            r_o_pos  <= bve_pkg::POS_W'(pos);
            r_o_eov  <= r_last;
            r_o_oor  <= r_oor;
            r_o_wrap <= sum[OW];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_codeword         = r_o_code;
    assign o_code_length      = r_o_len;
    assign o_bit_position     = r_o_pos;
    assign o_end_of_vector    = r_o_eov;
    assign o_out_of_range     = r_o_oor;
    assign o_position_wrapped = r_o_wrap;

endmodule

### design/bucketed_varlen_encoder.sv
// Timing: an item passes IDLE, CHECK, then STEP once per bucket walked (1 up to the set bits
// of coding), FIN and EMIT before its result is registered; raw coding and too-large values go
// from CHECK straight to EMIT. One item is taken at a time; the bucket loop visits one coding bit
// per cycle through a single lowest-set-bit unit, and EMIT waits for a free output register.
// Reset: synchronous, active low; config to reset values, position 0, vector start set,
// output register empty. No memories, so no clearing pass.
module bucketed_varlen_encoder #(
    parameter int DATA_WIDTH   = bve_pkg::DATA_WIDTH_DEF,
    parameter int OFFSET_WIDTH = bve_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bve_in_if.sink                        i_in,
    bve_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [bve_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bve_pkg::CFG_W-1:0]     i_cfg_data
);

    // Flow of one item:
    //   IDLE  - ready high; the element is sliced, sign-extended and zigzagged on entry
    //   CHECK - coding of zero gives the raw word; a value at or above coding is flagged
    //   STEP  - one bucket a cycle: take the lowest set coding bit, stop if the value
    //           fits or it is the final bucket, else subtract the bucket and count a skip
    //   FIN   - shift the body (value plus marker) by the skip count, check length <= 64
    //   EMIT  - wait for a free output register, then place the item and advance position
    // The output register decouples the sides: the next item is taken while a result waits.

    bve_pkg::t_dp_cmd cmd;
    bve_pkg::t_dp_sts sts;
    logic             in_ready;

    bve_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bve_datapath #(
        .DATA_WIDTH   (DATA_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_value            (i_in.value),
        .i_last_in_vector   (i_in.last_in_vector),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_codeword         (o_out.codeword),
        .o_code_length      (o_out.code_length),
        .o_bit_position     (o_out.bit_position),
        .o_end_of_vector    (o_out.end_of_vector),
        .o_out_of_range     (o_out.out_of_range),
        .o_position_wrapped (o_out.position_wrapped)
    );

    // ready only in IDLE: one item in flight at a time
    assign i_in.ready = in_ready;

endmodule

### design/bve_checker.sv
// Port-level checker of the encoder, attached to the top level by bind.
// Depends on bve_pkg and bucketed_varlen_encoder_macros.svh.
`include "bucketed_varlen_encoder_macros.svh"

module bve_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [bve_pkg::CODE_W-1:0]   i_codeword,
    input logic [bve_pkg::LEN_W-1:0]    i_code_length,
    input logic                         i_out_of_range
);

    // a stalled result stays offered
    `BVE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // flagged items carry no code bits
    `BVE_ASSERT_IMPL(a_oor_empty, i_clk, i_rst_n, i_out_valid && i_out_of_range, (i_codeword == '0) && (i_code_length == '0))
    // no code exceeds the output word
    `BVE_ASSERT_IMPL(a_len_max, i_clk, i_rst_n, i_out_valid, i_code_length <= 7'd64)
    // one item in flight: ready drops after an accept
    `BVE_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_rst_n && i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind bucketed_varlen_encoder bve_checker u_bve_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_codeword     (o_out.codeword),
    .i_code_length  (o_out.code_length),
    .i_out_of_range (o_out.out_of_range)
);
